// File: hw/rtl/mpq_pkg.sv
// Shared types and constants for the minimum priority queue.
package mpq_pkg;

	localparam int VALUE_W     = 32;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;

	localparam logic signed [VALUE_W-1:0] EMPTY_ANSWER = -32'sd1;

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_PEEK    = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctl_cmd_t;

endpackage

// File: hw/rtl/min_priority_queue_unit.sv
// Top level of the bounded sorted minimum priority queue.
// Holds up to DEPTH signed 32-bit values in ascending order in a row of
// compare-and-shift cells; enqueue places a value after equal ones, dequeue
// and peek return the head. Each request word is first captured; then the
// cell row inserts or shifts and loads the result register. The next request
// is taken right after that, while the previous response word may still wait
// for the downstream side; an execute waits only while a response word is
// stalled. Dequeue or peek on an empty queue answers -1 with empty status;
// enqueue on a full queue is dropped with full status. count_after carries
// the low five bits of the entry count.
module min_priority_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic [mpq_pkg::OP_W-1:0]              operation,
	input  logic signed [mpq_pkg::VALUE_W-1:0]    value,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output logic signed [mpq_pkg::VALUE_W-1:0]    result_value,
	output logic [mpq_pkg::STATUS_W-1:0]          status,
	output logic [mpq_pkg::COUNT_OUT_W-1:0]       count_after,
	output logic                                  is_empty
);

	mpq_pkg::ctl_cmd_t cmd;

	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	mpq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (operation),
		.value        (value),
		.result_value (result_value),
		.status       (status),
		.count_after  (count_after),
		.is_empty     (is_empty)
	);

endmodule

// File: hw/rtl/mpq_ctrl.sv
// Controller: request capture, execute sequencing and response valid.
module mpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output mpq_pkg::ctl_cmd_t cmd
);

	mpq_pkg::state_t state_q, state_d;
	logic            rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpq_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			mpq_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = mpq_pkg::S_EXEC;
				end
			end
			mpq_pkg::S_EXEC: begin
				// output slot must be free before the result register is reloaded
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.execute = 1'b1;
					state_d     = mpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mpq_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// File: hw/rtl/mpq_datapath.sv
// Datapath: row of sorted compare-and-shift cells, entry count and result register.
module mpq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mpq_pkg::ctl_cmd_t                     cmd,
	input  logic [mpq_pkg::OP_W-1:0]              operation,
	input  logic signed [mpq_pkg::VALUE_W-1:0]    value,
	output logic signed [mpq_pkg::VALUE_W-1:0]    result_value,
	output logic [mpq_pkg::STATUS_W-1:0]          status,
	output logic [mpq_pkg::COUNT_OUT_W-1:0]       count_after,
	output logic                                  is_empty
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [mpq_pkg::OP_W-1:0]           op_q;
	logic signed [mpq_pkg::VALUE_W-1:0] value_q;
	logic [CW-1:0]                      count_q;
	logic signed [mpq_pkg::VALUE_W-1:0] entry_q [DEPTH];

	logic [DEPTH-1:0]                   ins;
	logic signed [mpq_pkg::VALUE_W-1:0] ins_data [DEPTH];
	logic signed [mpq_pkg::VALUE_W-1:0] deq_data [DEPTH];
	logic                               full, empty;
	logic                               do_insert, do_remove;
	logic [CW-1:0]                      count_d;
	logic signed [mpq_pkg::VALUE_W-1:0] res_d;
	logic [mpq_pkg::STATUS_W-1:0]       status_d;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// ins[i]: cell i is at or past the insertion point (holds a larger value or is unused)
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ins[i] = (CW'(i) >= count_q) || (entry_q[i] > value_q);
		end
		ins_data[0] = ins[0] ? value_q : entry_q[0];
		for (int i = 1; i < DEPTH; i++) begin
			if (!ins[i]) begin
				ins_data[i] = entry_q[i];
			end else if (!ins[i-1]) begin
				ins_data[i] = value_q;
			end else begin
				ins_data[i] = entry_q[i-1];
			end
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			deq_data[i] = entry_q[i+1];
		end
		deq_data[DEPTH-1] = entry_q[DEPTH-1];
	end

	always_comb begin
		do_insert = 1'b0;
		do_remove = 1'b0;
		count_d   = count_q;
		res_d     = '0;
		status_d  = mpq_pkg::ST_OK;
		case (op_q)
			mpq_pkg::OP_ENQUEUE: begin
				if (full) begin
					status_d = mpq_pkg::ST_FULL;
				end else begin
					do_insert = 1'b1;
					count_d   = count_q + CW'(1);
				end
			end
			mpq_pkg::OP_DEQUEUE, mpq_pkg::OP_PEEK: begin
				if (empty) begin
					res_d    = mpq_pkg::EMPTY_ANSWER;
					status_d = mpq_pkg::ST_EMPTY;
				end else begin
					res_d = entry_q[0];
					if (op_q == mpq_pkg::OP_DEQUEUE) begin
						do_remove = 1'b1;
						count_d   = count_q - CW'(1);
					end
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			value_q <= value;
		end
		if (cmd.execute) begin
			result_value <= res_d;
			status       <= status_d;
			count_after  <= mpq_pkg::COUNT_OUT_W'(count_d);
			is_empty     <= (count_d == '0);
			for (int i = 0; i < DEPTH; i++) begin
				if (do_insert) begin
					entry_q[i] <= ins_data[i];
				end else if (do_remove) begin
					entry_q[i] <= deq_data[i];
				end
			end
		end
	end

endmodule

// File: hw/rtl/mpq_checker.sv
// Port-level checker for the priority queue, bound to the top level.
module mpq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_stall,
	input logic                               rsp_valid,
	input logic                               rsp_stall,
	input logic signed [mpq_pkg::VALUE_W-1:0] result_value,
	input logic [mpq_pkg::STATUS_W-1:0]       status,
	input logic [mpq_pkg::COUNT_OUT_W-1:0]    count_after,
	input logic                               is_empty
);

	// response word is held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(result_value) && $stable(status))
		else $error("response word changed or dropped while stalled");

	// a taken request blocks the next one for its execute cycle
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted in back-to-back cycles");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == mpq_pkg::ST_EMPTY |->
			result_value == mpq_pkg::EMPTY_ANSWER && count_after == '0 && is_empty)
		else $error("empty response inconsistent");

	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == mpq_pkg::ST_FULL |-> result_value == '0 && !is_empty)
		else $error("full response inconsistent");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status == mpq_pkg::ST_OK || status == mpq_pkg::ST_EMPTY
			|| status == mpq_pkg::ST_FULL)
		else $error("undefined status code");

endmodule

bind min_priority_queue_unit mpq_checker u_mpq_checker (.*);
